### hdl/voxel_value_histogram_core_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the histogram core.
// ---------------------------------------------------------------------------
`ifndef VOXEL_VALUE_HISTOGRAM_CORE_DEFINES_SVH
`define VOXEL_VALUE_HISTOGRAM_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define VVH_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define VVH_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/vvh_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vvh_pkg
// Shared constants and types of the voxel value histogram core.
// ---------------------------------------------------------------------------
package vvh_pkg;

  localparam int VALUE_BITS     = 16;
  localparam int NARROW_BITS    = 8;
  localparam int STORE_DEPTH    = 1 << VALUE_BITS;
  localparam int COUNT_BITS     = 31;
  localparam int IN_DATA_BITS   = 16;
  localparam int OUT_DATA_BITS  = 32;
  localparam int QUEUE_DEPTH    = 4;
  localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

  typedef enum logic {
    REQ_COUNT = 1'b0,
    REQ_READ  = 1'b1
  } req_kind_t;

  typedef struct packed {
    req_kind_t             kind;
    logic [VALUE_BITS-1:0] index;
  } vvh_req_t;

  typedef struct packed {
    logic empty;
    logic full;
  } vvh_q_status_t;

endpackage

### hdl/voxel_value_histogram_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// voxel_value_histogram_core
// Saturating histogram of voxel values over a 65536-bin store.
// ---------------------------------------------------------------------------
// Usage:
//   Slave channel (s_*): one item per handshake. tuser selects the request:
//   0 counts the voxel in tdata, 1 reads the count of bin tdata. Count items
//   produce nothing on the output; read items produce one item.
//   Master channel (m_*): tdata[30:0] is the saturated bin count.
//   cfg_wr_en/cfg_wr_data write the mode bit: 0 = 8-bit voxels (256 bins,
//   values masked to 8 bits), 1 = 16-bit voxels. Write it only while idle.
// Path: a read item goes through the queue, the store read and the result
//   register. The back reads the bin of each item, writes it back for count
//   items and takes no new item until done; a 4-entry queue buffers bursts.
// Reset: rst starts a clearing pass that zeroes all 65536 bins;
//   s_tready stays low until it ends. The mode bit resets to 8-bit.
// Stall: the result register holds while m_tready is low; the queue keeps
//   taking items until it fills, then s_tready drops.
// ---------------------------------------------------------------------------
`include "voxel_value_histogram_core_defines.svh"

module voxel_value_histogram_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic                               cfg_wr_data,    // voxel_is_wide
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [vvh_pkg::IN_DATA_BITS-1:0]   s_tdata,        // [15:0] voxel_value
  input  logic                               s_tuser,        // [0] req_type
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [vvh_pkg::OUT_DATA_BITS-1:0]  m_tdata         // [30:0] bin_count, [31] zero
);
  import vvh_pkg::*;

  logic                  push;
  vvh_req_t              push_req;
  logic                  pop;
  vvh_req_t              head;
  vvh_q_status_t         q_status;
  logic                  clear_busy;
  logic [COUNT_BITS-1:0] m_count;

  // Front: mode register, handshake, index masking.
  vvh_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .q_status    (q_status),
    .clear_busy  (clear_busy),
    .push        (push),
    .push_req    (push_req)
  );

  // Decouple the input side from the store sequencer.
  vvh_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_req (push_req),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  // Back: clear sweep, read-modify-write of the bin, result register.
  vvh_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .q_status   (q_status),
    .pop        (pop),
    .clear_busy (clear_busy),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_count    (m_count)
  );

  // Pad the count to a whole number of bytes.
  assign m_tdata = OUT_DATA_BITS'(m_count);

  `VVH_ASSERT_NOW(a_no_push_when_full, clk, rst, q_status.full, !push,
    "item pushed into a full queue")
  `VVH_ASSERT_NOW(a_queue_empty_in_clear, clk, rst, clear_busy, q_status.empty,
    "queue holds items during the clearing pass")
  `VVH_ASSERT_NEXT(a_pop_fills_slot, clk, rst, pop, !pop,
    "back took two items in consecutive cycles")

endmodule

### hdl/vvh_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vvh_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module vvh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Hold read data when no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/vvh_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vvh_front
// Mode register, input handshake and bin index masking.
// ---------------------------------------------------------------------------
module vvh_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic                              cfg_wr_data,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [vvh_pkg::IN_DATA_BITS-1:0]  s_tdata,
  input  logic                              s_tuser,
  input  vvh_pkg::vvh_q_status_t            q_status,
  input  logic                              clear_busy,
  output logic                              push,
  output vvh_pkg::vvh_req_t                 push_req
);
  import vvh_pkg::*;

  logic voxel_is_wide;

  always_ff @(posedge clk) begin
    if (rst) begin
      voxel_is_wide <= 1'b0;
    end else if (cfg_wr_en) begin
      voxel_is_wide <= cfg_wr_data;
    end
  end

  // Hold off items while the store is being cleared or the queue is full.
  assign s_tready = !q_status.full && !clear_busy;
  assign push     = s_tvalid && s_tready;

  always_comb begin
    push_req.kind = req_kind_t'(s_tuser);
    if (voxel_is_wide) begin
      push_req.index = s_tdata[VALUE_BITS-1:0];
    end else begin
      push_req.index = VALUE_BITS'(s_tdata[NARROW_BITS-1:0]);
    end
  end

endmodule

### hdl/vvh_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vvh_queue
// Short request queue between the front and the back.
// ---------------------------------------------------------------------------
module vvh_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  vvh_pkg::vvh_req_t      push_req,
  input  logic                   pop,
  output vvh_pkg::vvh_req_t      head,
  output vvh_pkg::vvh_q_status_t status
);
  import vvh_pkg::*;

  vvh_req_t                  entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr;
  logic [QUEUE_PTR_BITS-1:0] rd_ptr;
  logic [QUEUE_PTR_BITS:0]   count;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign head         = entries[rd_ptr];
  assign status.empty = (count == '0);
  assign status.full  = (count == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));

endmodule

### hdl/vvh_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vvh_back
// Clearing sweep, bin read-modify-write and result register.
// ---------------------------------------------------------------------------
module vvh_back (
  input  logic                              clk,
  input  logic                              rst,
  input  vvh_pkg::vvh_req_t                 head,
  input  vvh_pkg::vvh_q_status_t            q_status,
  output logic                              pop,
  output logic                              clear_busy,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [vvh_pkg::COUNT_BITS-1:0]    m_count
);
  import vvh_pkg::*;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK
  } state_t;

  state_t                state;
  logic [VALUE_BITS-1:0] clr_addr;
  vvh_req_t              cur;

  logic                  ram_we;
  logic [VALUE_BITS-1:0] ram_waddr;
  logic [COUNT_BITS-1:0] ram_wdata;
  logic [COUNT_BITS-1:0] ram_rdata;
  logic [COUNT_BITS-1:0] count_inc;
  logic                  out_free;

  vvh_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (pop),
    .raddr (head.index),
    .rdata (ram_rdata)
  );

  // Stop at the all-ones count.
  assign count_inc = (&ram_rdata) ? ram_rdata : ram_rdata + COUNT_BITS'(1);
  assign out_free  = !m_tvalid || m_tready;
  assign pop       = (state == ST_IDLE) && !q_status.empty;
  assign clear_busy = (state == ST_CLEAR);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur.index;
    ram_wdata = count_inc;
    unique case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
      end
      ST_LOOK: begin
        ram_we = (cur.kind == REQ_COUNT);
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // Load a new result, or drop the one just taken.
      if (state == ST_LOOK && cur.kind == REQ_READ && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (&clr_addr) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (pop) begin
            cur   <= head;
            state <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          if (cur.kind == REQ_COUNT) begin
            state <= ST_IDLE;
          end else if (out_free) begin
            m_count  <= ram_rdata;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### bench/vvh_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vvh_checker
// Watches the histogram channels, keeps its own bin tally and checks each
// read result against the oldest predicted count.
// ---------------------------------------------------------------------------
module vvh_checker
  import vvh_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_wr_en,
  input  logic                     cfg_wr_data,
  input  logic                     s_tvalid,
  input  logic                     s_tready,
  input  logic [IN_DATA_BITS-1:0]  s_tdata,
  input  logic                     s_tuser,
  input  logic                     m_tvalid,
  input  logic                     m_tready,
  input  logic [OUT_DATA_BITS-1:0] m_tdata,
  output int                       mismatches,
  output int                       outstanding
);

  localparam bit [COUNT_BITS-1:0] COUNT_CEIL = {COUNT_BITS{1'b1}};

  bit [COUNT_BITS-1:0] bin_tally [STORE_DEPTH];
  bit                  wide_voxels;
  bit [COUNT_BITS-1:0] pending_counts [$];

  initial mismatches = 0;

  task automatic report_mismatch(input string what);
    $display("checker @%0t: %s", $realtime, what);
    mismatches++;
  endtask

  // Narrow mode keeps the low byte; wide mode keeps all VALUE_BITS bits.
  function automatic bit [VALUE_BITS-1:0] bin_of(input bit [IN_DATA_BITS-1:0] value);
    bit [VALUE_BITS-1:0] idx;
    idx = value[VALUE_BITS-1:0];
    if (!wide_voxels) idx = {{(VALUE_BITS-NARROW_BITS){1'b0}}, value[NARROW_BITS-1:0]};
    return idx;
  endfunction

  task automatic tally_request(input req_kind_t kind, input bit [IN_DATA_BITS-1:0] value);
    bit [VALUE_BITS-1:0] idx;
    idx = bin_of(value);
    if (kind == REQ_COUNT) begin
      if (bin_tally[idx] != COUNT_CEIL) bin_tally[idx] = bin_tally[idx] + 1'b1;
    end else begin
      pending_counts.push_back(bin_tally[idx]);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      foreach (bin_tally[i]) bin_tally[i] = '0;
      wide_voxels = 1'b0;
      pending_counts.delete();
    end else begin
      if (cfg_wr_en) wide_voxels = cfg_wr_data;
      if (s_tvalid && s_tready) tally_request(req_kind_t'(s_tuser), s_tdata);
      if (m_tvalid && m_tready) begin
        if (pending_counts.size() == 0) begin
          report_mismatch($sformatf("unexpected result, count %0d", m_tdata));
        end else begin
          bit [COUNT_BITS-1:0] want;
          want = pending_counts.pop_front();
          if (m_tdata !== {{(OUT_DATA_BITS-COUNT_BITS){1'b0}}, want})
            report_mismatch($sformatf("bin_count %0d, predicted %0d", m_tdata, want));
        end
      end
    end
    outstanding = pending_counts.size();
  end

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Stimulus for the voxel histogram core: directed corner items, then random
// phases in both voxel modes with random gaps and output stalls. A checker
// beside the core predicts every bin count and reports mismatches.
// ---------------------------------------------------------------------------
module tb_top;
  import vvh_pkg::*;

  localparam int PHASE_ITEMS = 250;
  localparam int SETTLE_CYCLES = 16;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic cfg_wr_data = 1'b0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_DATA_BITS-1:0] s_tdata = '0;    // [15:0] voxel_value
  logic s_tuser = 1'b0;                     // [0] req_type
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] m_tdata;        // [30:0] bin_count, [31] zero

  int mismatches;
  int outstanding;
  bit calm_stretch = 1'b0;                  // both sides run without idling

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  voxel_value_histogram_core dut (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  vvh_checker u_checker (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  function automatic int draw_wait();
    return calm_stretch ? 0 : $urandom_range(0, 8);
  endfunction

  // Offer one item from a falling edge and hold it until the core takes it.
  // Called and returning at a falling edge.
  task automatic push_item(input req_kind_t kind, input logic [IN_DATA_BITS-1:0] value);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    s_tuser  <= kind;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // Drain every pending read, let the pipeline settle, then write the mode.
  task automatic write_mode(input logic wide);
    s_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= wide;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Mostly hit a small set of hot bins so reads see real counts; the rest
  // spread over the full 16-bit range.
  task automatic run_phase(input int n_items);
    logic [IN_DATA_BITS-1:0] hot [16];
    logic [IN_DATA_BITS-1:0] value;
    req_kind_t kind;
    foreach (hot[i]) hot[i] = IN_DATA_BITS'($urandom_range(0, 65535));
    repeat (n_items) begin
      kind  = ($urandom_range(0, 9) < 3) ? REQ_READ : REQ_COUNT;
      if ($urandom_range(0, 3) == 0) begin
        value = IN_DATA_BITS'($urandom_range(0, 65535));
      end else begin
        value = hot[$urandom_range(0, 15)];
      end
      push_item(kind, value);
    end
  endtask

  // Output side: stall a random number of cycles before taking each result.
  initial begin
    int stall;
    @(negedge clk);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      @(negedge clk);
    end
  end

  initial begin
    bit phase_wide [7] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    // Hold off until the clearing pass has zeroed the store.
    @(negedge clk);
    while (!s_tready) @(negedge clk);
    write_mode(1'b0);

    // Narrow mode: byte extremes and upper bits that must be masked away.
    push_item(REQ_READ,  16'h0000);
    push_item(REQ_COUNT, 16'h0000);
    push_item(REQ_COUNT, 16'h00FF);
    push_item(REQ_COUNT, 16'hFFFF);
    push_item(REQ_COUNT, 16'h0100);
    push_item(REQ_COUNT, 16'hAB55);
    push_item(REQ_READ,  16'h0000);
    push_item(REQ_READ,  16'h00FF);
    push_item(REQ_READ,  16'hFF00);
    push_item(REQ_READ,  16'h1255);
    push_item(REQ_READ,  16'h01FF);
    write_mode(1'b1);

    // Wide mode: bins below 256 keep their narrow counts, upper bins are new.
    push_item(REQ_READ,  16'h00FF);
    push_item(REQ_READ,  16'h0100);
    push_item(REQ_COUNT, 16'hFFFF);
    push_item(REQ_COUNT, 16'h8000);
    push_item(REQ_COUNT, 16'h00FF);
    push_item(REQ_COUNT, 16'h7FFF);
    push_item(REQ_READ,  16'hFFFF);
    push_item(REQ_READ,  16'h8000);
    push_item(REQ_READ,  16'h00FF);
    push_item(REQ_READ,  16'h7FFF);
    write_mode(1'b0);

    // Back to narrow: the wide write to bin 0xFF must still be there.
    push_item(REQ_READ,  16'hFFFF);
    push_item(REQ_READ,  16'h8000);

    foreach (phase_wide[p]) begin
      write_mode(phase_wide[p]);
      calm_stretch = (p == 2 || p == 5);
      run_phase(PHASE_ITEMS);
    end
    calm_stretch = 1'b0;

    s_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Cap the run well beyond the slowest legal pass, clearing pass included.
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
